### design/stalta_pkg.sv
package stalta_pkg;

    // fixed field widths
    localparam int SUM_W   = 37;
    localparam int LONG_W  = 13;
    localparam int SHORT_W = 11;
    localparam int GAP_W   = 12;
    localparam int POS_W   = 16;
    localparam int RATIO_W = 32;

    // product and divider widths
    localparam int NUM_W     = SUM_W + LONG_W;        // |short| * long_len
    localparam int DEN_W     = SUM_W - 1 + SHORT_W + 1; // long * short_len, room to spare
    localparam int DIVD_W    = NUM_W + 16;            // numerator scaled to Q16.16
    localparam int DIV_STEPS = DIVD_W;

    // register map
    localparam int REG_ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_LONG_LEN  = 2'd0,
        REG_SHORT_LEN = 2'd1,
        REG_GAP_LEN   = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

    localparam logic [LONG_W-1:0]  LONG_LEN_RST  = LONG_W'(1000);
    localparam logic [SHORT_W-1:0] SHORT_LEN_RST = SHORT_W'(100);
    localparam logic [GAP_W-1:0]   GAP_LEN_RST   = '0;

    localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
    localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

    // configuration as seen by the front
    typedef struct packed {
        logic [LONG_W-1:0]  long_len;
        logic [SHORT_W-1:0] short_len;
        logic [GAP_W-1:0]   gap_len;
    } cfg_t;

    // work item handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0] short_sum;
        logic signed [SUM_W-1:0] long_sum;
        logic [LONG_W-1:0]       lw;
        logic [SHORT_W-1:0]      sw;
        logic [POS_W-1:0]        position;
    } job_t;

endpackage

### design/stalta_in_if.sv
interface stalta_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_trace;

    modport source (output valid, sample, start_of_trace, input ready);
    modport sink   (input valid, sample, start_of_trace, output ready);
endinterface

### design/stalta_out_if.sv
interface stalta_out_if ();
    logic                                       valid;
    logic                                       ready;
    logic signed [stalta_pkg::RATIO_W-1:0]      ratio;
    logic [stalta_pkg::POS_W-1:0]               position;
    logic                                       long_not_positive;

    modport source (output valid, ratio, position, long_not_positive, input ready);
    modport sink   (input valid, ratio, position, long_not_positive, output ready);
endinterface

### design/stalta_front.sv
module stalta_front #(
    parameter int HISTORY_DEPTH = 8192,
    parameter int SAMPLE_BITS   = 24,
    parameter int MAX_TRACE_LEN = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stalta_pkg::cfg_t              cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_start,
    output logic                          job_valid,
    input  logic                          job_ready,
    output stalta_pkg::job_t              job
);
    localparam int AW       = $clog2(HISTORY_DEPTH);
    localparam int SW       = stalta_pkg::SUM_W;
    localparam int SEEN_CAP = ((MAX_TRACE_LEN - 1) > 65535) ? 65535 : (MAX_TRACE_LEN - 1);
    localparam int DW       = 15;
    localparam int XW       = 18;

    typedef enum logic [2:0] {F_IDLE, F_RD_S, F_RD_E, F_RD_L, F_FIN} fstate_t;

    fstate_t                       state_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [15:0]                   k_reg;
    logic [15:0]                   seen_reg;
    logic [AW-1:0]                 wp_reg;
    logic signed [SW-1:0]          short_reg;
    logic signed [SW-1:0]          long_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic signed [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];

    logic [stalta_pkg::LONG_W-1:0]  lw;
    logic [stalta_pkg::SHORT_W-1:0] sw;
    logic [stalta_pkg::GAP_W-2:0]   gap2;
    logic [DW-1:0]                  ds, de, dl;
    logic                           use_s, use_e, use_l, emit;
    logic [AW-1:0]                  addr_s, addr_e, addr_l, rd_addr;
    logic signed [SW-1:0]           x_ext, h_ext;
    logic [15:0]                    seen_eff;
    logic                           wr_en;

    // ring address a given distance behind the write pointer
    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp, input logic [DW-1:0] d);
        logic [XW-1:0] diff;
        diff = XW'(wp) - XW'(d);
        if (diff[XW-1])
        begin
            diff = diff + XW'(HISTORY_DEPTH);
        end
        return diff[AW-1:0];
    endfunction

    // effective window lengths and distances
    always_comb
    begin
        lw     = (cfg.long_len == '0) ? stalta_pkg::LONG_W'(1) : cfg.long_len;
        sw     = (cfg.short_len == '0) ? stalta_pkg::SHORT_W'(1) : cfg.short_len;
        gap2   = cfg.gap_len[stalta_pkg::GAP_W-1:1];
        ds     = DW'(sw);
        de     = DW'({gap2, 1'b0}) + DW'(sw) + DW'(1);
        dl     = DW'({gap2, 1'b0}) + DW'(sw) + DW'(lw);
        use_s  = {1'b0, k_reg} >= 17'(ds);
        use_e  = {1'b0, k_reg} >= 17'(de);
        use_l  = {1'b0, k_reg} >= 17'(dl);
        emit   = use_l && (XW'(dl) <= XW'(HISTORY_DEPTH));
        addr_s = back_addr(wp_reg, ds);
        addr_e = back_addr(wp_reg, de);
        addr_l = back_addr(wp_reg, dl);
        x_ext  = {{(SW-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
        h_ext  = {{(SW-SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
        seen_eff = in_start ? '0 : seen_reg;
    end

    // read address follows the sequencer; held on the last tap while stalled
    always_comb
    begin
        unique case (state_reg)
            F_RD_S:  rd_addr = addr_s;
            F_RD_E:  rd_addr = addr_e;
            default: rd_addr = addr_l;
        endcase
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_FIN) && emit;
    assign wr_en     = (state_reg == F_FIN) && (!emit || job_ready);

    assign job.short_sum = short_reg;
    assign job.long_sum  = long_reg;
    assign job.lw        = lw;
    assign job.sw        = sw;
    assign job.position  = k_reg - 16'(sw) - 16'(gap2);

    // history ring
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wp_reg] <= x_reg;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // sample sequencer and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            seen_reg  <= '0;
            wp_reg    <= '0;
            short_reg <= '0;
            long_reg  <= '0;
            k_reg     <= '0;
            x_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_start)
                        begin
                            seen_reg  <= '0;
                            wp_reg    <= '0;
                            short_reg <= '0;
                            long_reg  <= '0;
                        end
                        x_reg <= in_sample;
                        k_reg <= seen_eff;
                        if (seen_eff < 16'(SEEN_CAP))
                        begin
                            state_reg <= F_RD_S;
                        end
                    end
                end
                F_RD_S:
                begin
                    state_reg <= F_RD_E;
                end
                F_RD_E:
                begin
                    // short window: add new sample, drop the oldest
                    short_reg <= short_reg + x_ext - (use_s ? h_ext : SW'(0));
                    state_reg <= F_RD_L;
                end
                F_RD_L:
                begin
                    if (use_e)
                    begin
                        long_reg <= long_reg + h_ext;
                    end
                    state_reg <= F_FIN;
                end
                F_FIN:
                begin
                    if (wr_en)
                    begin
                        if (use_l)
                        begin
                            long_reg <= long_reg - h_ext;
                        end
                        seen_reg  <= k_reg + 16'(1);
                        wp_reg    <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule

### design/stalta_fifo.sv
module stalta_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  stalta_pkg::job_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output stalta_pkg::job_t rd_data
);
    stalta_pkg::job_t slot_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### design/stalta_back.sv
module stalta_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  job_valid,
    output logic                                  job_ready,
    input  stalta_pkg::job_t                      job,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [stalta_pkg::RATIO_W-1:0] out_ratio,
    output logic [stalta_pkg::POS_W-1:0]          out_position,
    output logic                                  out_np
);
    localparam int NW = stalta_pkg::NUM_W;
    localparam int BW = stalta_pkg::DEN_W;
    localparam int VW = stalta_pkg::DIVD_W;
    localparam int RW = stalta_pkg::RATIO_W;
    localparam int SW = stalta_pkg::SUM_W;
    localparam int CW = $clog2(stalta_pkg::DIV_STEPS + 1);

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_CHK, B_DIV, B_OUT} bstate_t;

    bstate_t                       state_reg;
    logic                          neg_reg, np_reg, sat_reg;
    logic [SW-1:0]                 abs_reg;
    logic [SW-2:0]                 lsum_reg;
    logic [stalta_pkg::LONG_W-1:0]  lw_reg;
    logic [stalta_pkg::SHORT_W-1:0] sw_reg;
    logic [stalta_pkg::POS_W-1:0]  pos_reg;
    logic [NW-1:0]                 a_reg;
    logic [BW-1:0]                 b_reg;
    logic [VW-1:0]                 n_reg;
    logic [BW-1:0]                 rem_reg;
    logic [RW-1:0]                 q_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          out_valid_reg;
    logic [RW-1:0]                 ratio_reg;
    logic [stalta_pkg::POS_W-1:0]  pos_out_reg;
    logic                          np_out_reg;

    logic [BW:0]   rem_sh;
    logic          take;
    logic          out_free;
    logic [RW-1:0] result;

    // one restoring division step
    always_comb
    begin
        rem_sh   = {rem_reg, n_reg[VW-1]};
        take     = rem_sh >= {1'b0, b_reg};
        out_free = !out_valid_reg || out_ready;
        if (np_reg)
        begin
            result = '0;
        end
        else if (sat_reg)
        begin
            result = neg_reg ? stalta_pkg::RATIO_MIN : stalta_pkg::RATIO_MAX;
        end
        else
        begin
            result = neg_reg ? (RW'(0) - q_reg) : q_reg;
        end
    end

    assign job_ready    = (state_reg == B_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_ratio    = ratio_reg;
    assign out_position = pos_out_reg;
    assign out_np       = np_out_reg;

    // result register and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == B_OUT && out_free)
        begin
            ratio_reg   <= result;
            pos_out_reg <= pos_reg;
            np_out_reg  <= np_reg;
        end
    end

    // multiply, range check, divide, hand over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            np_reg        <= 1'b0;
            sat_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        neg_reg  <= job.short_sum[SW-1];
                        abs_reg  <= job.short_sum[SW-1] ? (SW'(0) - job.short_sum) : job.short_sum;
                        lsum_reg <= job.long_sum[SW-2:0];
                        lw_reg   <= job.lw;
                        sw_reg   <= job.sw;
                        pos_reg  <= job.position;
                        np_reg   <= job.long_sum[SW-1] || (job.long_sum == '0);
                        sat_reg  <= 1'b0;
                        state_reg <= (job.long_sum[SW-1] || (job.long_sum == '0)) ? B_OUT : B_MUL;
                    end
                end
                B_MUL:
                begin
                    a_reg     <= NW'(abs_reg) * NW'(lw_reg);
                    b_reg     <= BW'(lsum_reg) * BW'(sw_reg);
                    state_reg <= B_CHK;
                end
                B_CHK:
                begin
                    // integer part of 32768 or more saturates
                    if ({15'b0, a_reg} >= {2'b0, b_reg, 15'b0})
                    begin
                        sat_reg   <= 1'b1;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        n_reg     <= {a_reg, 16'b0};
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= CW'(stalta_pkg::DIV_STEPS);
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    n_reg   <= {n_reg[VW-2:0], 1'b0};
                    rem_reg <= take ? BW'(rem_sh - {1'b0, b_reg}) : rem_sh[BW-1:0];
                    q_reg   <= {q_reg[RW-2:0], take};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule

### design/sta_lta_onset_ratio.sv
// Short-term over long-term average ratio of a stream of envelope samples.
// samples: one beat per sample with a start_of_trace flag that restarts the
//   window sums and the sample count; handshake is valid/ready.
// ratios: one beat per sample from index long+gap+short onward (odd gap
//   rounded down; only while that fits the history depth), carrying the signed
//   Q16.16 ratio (saturated, zero if long sum <= 0), position, long_not_positive.
// Registers long_len, short_len, gap_len are written over the APB port at
//   byte addresses 0, 4 and 8; write them only while the block is idle.
// The front takes one sample at a time: accept, then three reads through the
//   history ring's single read port, then the last sum update and history write.
// The back goes straight to output for a non-positive long sum; otherwise a
//   product stage and range check follow and, unless the ratio saturates, a
//   66-step shift-subtract divider; sustained rate is set by that divider.
// A two-entry queue sits between front and back and the result waits in an
//   output register, so a stalled receiver first fills those, then stops
//   the front. Nothing is lost or repeated under stall.
// Reset clears sums, count and configuration to defaults; the history ring
//   is not cleared, which no read can observe within a trace.
module sta_lta_onset_ratio #(
    parameter int HISTORY_DEPTH = 8192,
    parameter int SAMPLE_BITS   = 24,
    parameter int MAX_TRACE_LEN = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [stalta_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    stalta_in_if.sink                            samples,
    stalta_out_if.source                         ratios
);
    stalta_pkg::cfg_t   cfg_reg;
    stalta_pkg::job_t   fj_data, bj_data;
    logic               fj_valid, fj_ready, bj_valid, bj_ready;
    logic               cfg_we;
    stalta_pkg::reg_index_t reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_sel = stalta_pkg::reg_index_t'(paddr[3:2]);

    // register read-back
    always_comb
    begin
        unique case (reg_sel)
            stalta_pkg::REG_LONG_LEN:  prdata = 32'(cfg_reg.long_len);
            stalta_pkg::REG_SHORT_LEN: prdata = 32'(cfg_reg.short_len);
            stalta_pkg::REG_GAP_LEN:   prdata = 32'(cfg_reg.gap_len);
            default:                   prdata = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_len  <= stalta_pkg::LONG_LEN_RST;
            cfg_reg.short_len <= stalta_pkg::SHORT_LEN_RST;
            cfg_reg.gap_len   <= stalta_pkg::GAP_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                stalta_pkg::REG_LONG_LEN:
                    cfg_reg.long_len <= pwdata[stalta_pkg::LONG_W-1:0];
                stalta_pkg::REG_SHORT_LEN:
                    cfg_reg.short_len <= pwdata[stalta_pkg::SHORT_W-1:0];
                stalta_pkg::REG_GAP_LEN:
                    cfg_reg.gap_len <= pwdata[stalta_pkg::GAP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    stalta_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .MAX_TRACE_LEN (MAX_TRACE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_sample (samples.sample),
        .in_start  (samples.start_of_trace),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj_data)
    );

    stalta_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj_data),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bj_data)
    );

    stalta_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (bj_valid),
        .job_ready    (bj_ready),
        .job          (bj_data),
        .out_valid    (ratios.valid),
        .out_ready    (ratios.ready),
        .out_ratio    (ratios.ratio),
        .out_position (ratios.position),
        .out_np       (ratios.long_not_positive)
    );
endmodule
